>>> rtl/sssd_pkg.sv
// Shared types, constants and a glyph function for the seven-segment scan driver.
// No dependencies; used by sssd_scan and seven_segment_scan_driver.
package sssd_pkg;

  localparam int unsigned DIGIT_COUNT_DEF = 4;
  localparam int unsigned SHOWN_MAX       = 4;

  // Decimal value path: 0..9999 fits in 14 bits
  localparam int unsigned VALUE_W   = 14;
  localparam logic [13:0] VALUE_MAX = 14'd9999;

  // Reciprocal multipliers, exact for every value up to 9999
  localparam int unsigned PROD_W      = 28;
  localparam logic [14:0] RECIP_1000  = 15'd16778;  // >> 24
  localparam logic [14:0] RECIP_100   = 15'd10486;  // >> 20
  localparam logic [14:0] RECIP_10    = 15'd13108;  // >> 17

  localparam logic [7:0] GLYPH_BLANK  = 8'h00;
  localparam logic [7:0] GLYPH_DEGREE = 8'h63;
  localparam logic [7:0] SEG_COLON    = 8'h80;
  localparam logic [7:0] SEG_ALL      = 8'hFF;

  // Register map (word index)
  localparam logic REG_MODE = 1'b0;

  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_RAW     = 3'd1,
    REQ_NUMBER  = 3'd2,
    REQ_TEMP    = 3'd3,
    REQ_TIME    = 3'd4,
    REQ_SET_ALL = 3'd5,
    REQ_CLEAR   = 3'd6,
    REQ_ALL_OFF = 3'd7
  } req_t;

  typedef struct packed {
    req_t            req;
    logic [3:0][7:0] bytes;   // bytes[0] is digit one
  } cmd_t;

  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0:    g = 8'h3F;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5B;
      4'd3:    g = 8'h4F;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6D;
      4'd6:    g = 8'h7D;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h6F;
      default: g = GLYPH_BLANK;
    endcase
    return g;
  endfunction

endpackage

>>> rtl/sssd_scan.sv
// Scan stage: digit store, scan index, segment level and the result register.
// Depends on sssd_pkg.
module sssd_scan
  import sssd_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       anode_mode,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_segments,
  output logic [3:0] out_digits,
  output logic       out_last
);

  localparam int unsigned IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int unsigned SHOWN = (DIGIT_COUNT < SHOWN_MAX) ? DIGIT_COUNT : SHOWN_MAX;

  logic             hold_valid;
  cmd_t             hold;
  logic [7:0]       store [DIGIT_COUNT];
  logic [IDX_W-1:0] scan_index;
  logic [IDX_W-1:0] scan_index_next;
  logic [7:0]       segment_level;
  logic [1:0]       clear_count;

  logic       slot_free;
  logic       emits;
  logic       fire;
  logic       done;
  logic [7:0] cur_byte;
  logic [3:0] sel;
  logic [7:0] scan_seg;
  logic [3:0] scan_dig;

  always_comb begin
    slot_free = !out_valid || out_ready;
    emits     = (hold.req == REQ_TICK) || (hold.req == REQ_CLEAR) ||
                (hold.req == REQ_ALL_OFF);
    fire      = hold_valid && (!emits || slot_free);
    done      = fire && ((hold.req != REQ_CLEAR) || (clear_count == 2'd3));
    cmd_ready = !hold_valid || done;

    cur_byte = (hold.req == REQ_CLEAR) ? GLYPH_BLANK : store[scan_index];
    for (int j = 0; j < 4; j++) begin
      sel[j] = (int'(scan_index) == j);
    end
    scan_seg = anode_mode ? ~cur_byte : cur_byte;
    scan_dig = anode_mode ? sel : ~sel;
    scan_index_next = (scan_index == IDX_W'(DIGIT_COUNT - 1)) ? '0 : scan_index + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid    <= 1'b0;
      out_valid     <= 1'b0;
      scan_index    <= '0;
      segment_level <= '0;
      clear_count   <= '0;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        store[k] <= '0;
      end
    end else begin
      if (fire && emits) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd_ready) begin
        hold_valid <= cmd_valid;
      end

      if (fire) begin
        unique case (hold.req)
          REQ_TICK: begin
            segment_level <= scan_seg;
            scan_index    <= scan_index_next;
          end
          REQ_CLEAR: begin
            if (clear_count == 2'd0) begin
              for (int k = 0; k < DIGIT_COUNT; k++) begin
                store[k] <= '0;
              end
            end
            segment_level <= scan_seg;
            scan_index    <= scan_index_next;
            clear_count   <= clear_count + 2'd1;
          end
          REQ_RAW, REQ_NUMBER, REQ_TEMP, REQ_TIME: begin
            for (int k = 0; k < SHOWN; k++) begin
              store[k] <= hold.bytes[k];
            end
          end
          REQ_SET_ALL: begin
            for (int k = 0; k < DIGIT_COUNT; k++) begin
              store[k] <= SEG_ALL;
            end
          end
          REQ_ALL_OFF: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      hold <= cmd;
    end
    if (fire && emits) begin
      if (hold.req == REQ_ALL_OFF) begin
        out_segments <= segment_level;
        out_digits   <= anode_mode ? 4'h0 : 4'hF;
        out_last     <= 1'b1;
      end else begin
        out_segments <= scan_seg;
        out_digits   <= scan_dig;
        out_last     <= (hold.req != REQ_CLEAR) || (clear_count == 2'd3);
      end
    end
  end

endmodule

>>> rtl/seven_segment_scan_driver.sv
// Top level of the multiplexed seven-segment scan driver: stream ports, config
// register and decimal formatting pipeline. Depends on sssd_pkg and sssd_scan.
//
// Requests are accepted one per cycle unless stalled, and pass through three
// formatting registers (raw request, saturated value, decimal quotients) and
// combinational glyphs into the scan stage's hold and result registers. Unless
// the result side stalls, ticks, loads and all-off sustain one request per cycle
// and a clear occupies the scan stage for four results, one per cycle, through
// the single result register. Configuration (common anode mode, word 0) must be
// written only while no request is in flight; the block does not enforce this.
module seven_segment_scan_driver
  import sssd_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // number_value[15:0], zero_pad[16], hour_value[23:17],
                                 // minute_value[30:24], raw_segments[62:31], zero[63]
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // segment_lines[7:0], digit_lines[11:8], zero[15:12]
  output logic        m_tlast    // last_result
);

  logic common_anode_mode;

  // stage 0: raw request
  logic        v0;
  req_t        req0;
  logic [15:0] num0;
  logic        pad0;
  logic [6:0]  hour0;
  logic [6:0]  min0;
  logic [31:0] raw0;
  // stage 1: saturated value
  logic               v1;
  req_t               req1;
  logic [VALUE_W-1:0] val1;
  logic               pad1;
  logic [31:0]        raw1;
  // stage 2: quotients
  logic               v2;
  req_t               req2;
  logic [VALUE_W-1:0] val2;
  logic [3:0]         q1000;
  logic [6:0]         q100;
  logic [9:0]         q10;
  logic               pad2;
  logic [31:0]        raw2;

  logic free0, free1, free2;
  logic cmd_ready;
  cmd_t cmd;

  logic [15:0] mag;
  logic [18:0] temp_val;
  logic [14:0] time_val;
  logic [VALUE_W-1:0] val1_next;
  logic pad1_next;

  logic [PROD_W-1:0] prod1000, prod100, prod10;

  logic [6:0]  ten_q1000, diff1;
  logic [9:0]  ten_q100, diff2;
  logic [13:0] ten_q10, diff3;
  logic [3:0]  d0, d1, d2, d3;
  logic [7:0]  g0, g1, g2, g3;

  logic [7:0]  seg_out;
  logic [3:0]  dig_out;

  // config
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      common_anode_mode <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MODE)) begin
      common_anode_mode <= pwdata[0];
    end
  end
  assign prdata = (paddr[2] == REG_MODE) ? {31'd0, common_anode_mode} : 32'd0;

  // flow control
  assign free2    = !v2 || cmd_ready;
  assign free1    = !v1 || free2;
  assign free0    = !v0 || free1;
  assign s_tready = free0;

  // stage 0 -> 1
  always_comb begin
    mag      = num0[15] ? (~num0 + 16'd1) : num0;
    temp_val = ({3'd0, mag} << 3) + ({3'd0, mag} << 1);
    time_val = ({8'd0, hour0} << 6) + ({8'd0, hour0} << 5) + ({8'd0, hour0} << 2)
             + {8'd0, min0};
    unique case (req0)
      REQ_TEMP: val1_next = (temp_val > 19'(VALUE_MAX)) ? VALUE_MAX : temp_val[13:0];
      REQ_TIME: val1_next = (time_val > 15'(VALUE_MAX)) ? VALUE_MAX : time_val[13:0];
      default:  val1_next = (mag > 16'(VALUE_MAX)) ? VALUE_MAX : mag[13:0];
    endcase
    pad1_next = (req0 == REQ_TIME) || ((req0 == REQ_NUMBER) && pad0);
  end

  // stage 1 -> 2
  always_comb begin
    prod1000 = PROD_W'(val1) * PROD_W'(RECIP_1000);
    prod100  = PROD_W'(val1) * PROD_W'(RECIP_100);
    prod10   = PROD_W'(val1) * PROD_W'(RECIP_10);
  end

  // stage 2 -> scan: digits, glyphs, blanking
  always_comb begin
    ten_q1000 = ({3'd0, q1000} << 3) + ({3'd0, q1000} << 1);
    diff1     = q100 - ten_q1000;
    ten_q100  = ({3'd0, q100} << 3) + ({3'd0, q100} << 1);
    diff2     = q10 - ten_q100;
    ten_q10   = ({4'd0, q10} << 3) + ({4'd0, q10} << 1);
    diff3     = val2 - ten_q10;
    d0 = q1000;
    d1 = diff1[3:0];
    d2 = diff2[3:0];
    d3 = diff3[3:0];
    g0 = digit_glyph(d0);
    g1 = digit_glyph(d1);
    g2 = digit_glyph(d2);
    g3 = digit_glyph(d3);
    if (!pad2 && (d0 == 4'd0)) begin
      g0 = GLYPH_BLANK;
    end
    if (!pad2 && (d0 == 4'd0) && (d1 == 4'd0)) begin
      g1 = GLYPH_BLANK;
    end
    if (!pad2 && (d0 == 4'd0) && (d1 == 4'd0) && (d2 == 4'd0)) begin
      g2 = GLYPH_BLANK;
    end
    cmd.req = req2;
    unique case (req2)
      REQ_RAW:  cmd.bytes = raw2;
      REQ_TEMP: cmd.bytes = {GLYPH_DEGREE, g2, g1, g0};
      REQ_TIME: cmd.bytes = {g3, g2, g1 | SEG_COLON, g0};
      default:  cmd.bytes = {g3, g2, g1, g0};
    endcase
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (free0) v0 <= s_tvalid;
      if (free1) v1 <= v0;
      if (free2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (free0 && s_tvalid) begin
      req0  <= req_t'(s_tuser);
      num0  <= s_tdata[15:0];
      pad0  <= s_tdata[16];
      hour0 <= s_tdata[23:17];
      min0  <= s_tdata[30:24];
      raw0  <= s_tdata[62:31];
    end
    if (free1 && v0) begin
      req1 <= req0;
      val1 <= val1_next;
      pad1 <= pad1_next;
      raw1 <= raw0;
    end
    if (free2 && v1) begin
      req2  <= req1;
      val2  <= val1;
      q1000 <= prod1000[27:24];
      q100  <= prod100[26:20];
      q10   <= prod10[26:17];
      pad2  <= pad1;
      raw2  <= raw1;
    end
  end

  sssd_scan #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .anode_mode   (common_anode_mode),
    .cmd_valid    (v2),
    .cmd          (cmd),
    .cmd_ready    (cmd_ready),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_segments (seg_out),
    .out_digits   (dig_out),
    .out_last     (m_tlast)
  );

  assign m_tdata = {4'd0, dig_out, seg_out};

endmodule

>>> verif/tb_seven_segment_scan_driver.sv
`timescale 1ns / 1ps
// Self-checking testbench for seven_segment_scan_driver: drives the request and
// config ports, predicts the scan results and compares them. Needs sssd_pkg.
module tb_seven_segment_scan_driver;
  import sssd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned HOLD_AT_RESULT = 40;

  typedef struct packed {
    logic [31:0] raw;
    logic [6:0]  minute;
    logic [6:0]  hour;
    logic        pad;
    logic [15:0] value;
  } request_fields_t;

  typedef struct {
    logic [7:0] seg;
    logic [3:0] dig;
    logic       last;
  } pin_frame_t;

  class display_scoreboard;
    const logic [7:0] font [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                    8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
    logic [7:0]  seg_store [4];
    logic [1:0]  scan_pos;
    logic [7:0]  seg_level;
    bit          anode;
    pin_frame_t  frames_due [$];
    int unsigned errors;
    int unsigned frames_checked;

    function new();
      foreach (seg_store[k]) seg_store[k] = 8'h00;
      scan_pos = 2'd0;
      seg_level = 8'h00;
      anode = 1'b0;
      errors = 0;
      frames_checked = 0;
    endfunction

    task report(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    function int unsigned pending();
      return frames_due.size();
    endfunction

    function void show_value(input int unsigned mag, input bit pad);
      int unsigned d [4];
      logic [7:0]  g [4];
      if (mag > 9999) mag = 9999;
      d[0] = mag / 1000;
      d[1] = (mag % 1000) / 100;
      d[2] = (mag % 100) / 10;
      d[3] = mag % 10;
      for (int k = 0; k < 4; k++) g[k] = font[d[k]];
      if (!pad) begin
        if (d[0] == 0) g[0] = 8'h00;
        if (d[0] == 0 && d[1] == 0) g[1] = 8'h00;
        if (d[0] == 0 && d[1] == 0 && d[2] == 0) g[2] = 8'h00;
      end
      for (int k = 0; k < 4; k++) seg_store[k] = g[k];
    endfunction

    function void scan_digit(input bit last);
      logic [3:0] sel;
      logic [3:0] dig;
      sel = 4'b0001 << scan_pos;
      if (anode) begin
        seg_level = ~seg_store[scan_pos];
        dig = sel;
      end else begin
        seg_level = seg_store[scan_pos];
        dig = ~sel;
      end
      frames_due.push_back('{seg_level, dig, last});
      scan_pos = scan_pos + 2'd1;
    endfunction

    function void note_request(input req_t kind, input request_fields_t f);
      int unsigned mag;
      mag = f.value[15] ? (32'h10000 - {16'h0, f.value}) : {16'h0, f.value};
      case (kind)
        REQ_TICK: scan_digit(1'b1);
        REQ_RAW: begin
          for (int k = 0; k < 4; k++) seg_store[k] = f.raw[8*k +: 8];
        end
        REQ_NUMBER: show_value(mag, f.pad);
        REQ_TEMP: begin
          show_value(mag * 10, 1'b0);
          seg_store[3] = 8'h63;
        end
        REQ_TIME: begin
          show_value(int'(f.hour) * 100 + int'(f.minute), 1'b1);
          seg_store[1] = seg_store[1] | 8'h80;
        end
        REQ_SET_ALL: begin
          foreach (seg_store[k]) seg_store[k] = 8'hFF;
        end
        REQ_CLEAR: begin
          foreach (seg_store[k]) seg_store[k] = 8'h00;
          for (int k = 0; k < 4; k++) scan_digit(k == 3);
        end
        default: frames_due.push_back('{seg_level, anode ? 4'h0 : 4'hF, 1'b1});
      endcase
    endfunction

    task check_result(input logic [15:0] data, input logic last);
      pin_frame_t want;
      if (frames_due.size() == 0) begin
        report($sformatf("result with nothing pending: data %h last %b", data, last));
        return;
      end
      want = frames_due.pop_front();
      frames_checked++;
      if (data[7:0] !== want.seg)
        report($sformatf("segment lines %h, want %h", data[7:0], want.seg));
      if (data[11:8] !== want.dig)
        report($sformatf("digit lines %h, want %h", data[11:8], want.dig));
      if (data[15:12] !== 4'h0)
        report($sformatf("padding bits %h, want 0", data[15:12]));
      if (last !== want.last)
        report($sformatf("last flag %b, want %b", last, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = 64'h0;
  logic [2:0]  s_tuser = REQ_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  display_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  bit          send_steady = 1'b0;
  bit          hold_done = 1'b0;

  always #10 clk = ~clk;

  seven_segment_scan_driver i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, sb.pending());
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stalls, stretches without them, one long hold-off
  initial begin : result_sink
    int unsigned gap;
    bit          steady;
    steady = 1'b0;
    while (rst) @(posedge clk);
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata, m_tlast);
        results_seen++;
        if ($urandom_range(0, 9) == 0) steady = !steady;
        gap = steady ? 0 : $urandom_range(0, 17);
        if (results_seen == HOLD_AT_RESULT) begin
          gap = HOLD_CYCLES;
          hold_done = 1'b1;
        end
        if (gap != 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  task automatic cfg_write(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MODE, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.anode = value[0];
    @(posedge clk);
  endtask

  task automatic cfg_readback(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_MODE, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value)
      sb.report($sformatf("mode register reads %h, want %h", prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_request(input req_t kind, input request_fields_t f);
    int unsigned gap;
    if ($urandom_range(0, 9) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {1'b0, f};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(kind, f);
    requests_sent++;
  endtask

  task automatic put(input req_t kind, input logic [15:0] value, input logic pad,
                     input logic [6:0] hour, input logic [6:0] minute,
                     input logic [31:0] raw);
    request_fields_t f;
    f.value = value;
    f.pad = pad;
    f.hour = hour;
    f.minute = minute;
    f.raw = raw;
    send_request(kind, f);
  endtask

  task automatic ticks(input int unsigned n);
    repeat (n) put(REQ_TICK, 16'h0, 1'b0, 7'd0, 7'd0, 32'h0);
  endtask

  // wait for every pending result, then let commands without results drain
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic directed_requests();
    ticks(1);
    put(REQ_ALL_OFF, 16'h0, 1'b0, 7'd0, 7'd0, 32'h0);
    put(REQ_RAW, 16'h0, 1'b0, 7'd0, 7'd0, 32'h4F5B_063F);
    ticks(4);
    put(REQ_NUMBER, 16'hFFF6, 1'b0, 7'd0, 7'd0, 32'h0);
    ticks(4);
    put(REQ_NUMBER, 16'h8000, 1'b1, 7'd0, 7'd0, 32'h0);
    ticks(1);
    put(REQ_TEMP, 16'h8001, 1'b0, 7'd0, 7'd0, 32'h0);
    ticks(1);
    put(REQ_TEMP, 16'h0005, 1'b0, 7'd0, 7'd0, 32'h0);
    ticks(4);
    put(REQ_TIME, 16'h0, 1'b0, 7'd127, 7'd127, 32'h0);
    ticks(1);
    put(REQ_TIME, 16'h0, 1'b0, 7'd9, 7'd5, 32'h0);
    ticks(4);
    put(REQ_SET_ALL, 16'h0, 1'b0, 7'd0, 7'd0, 32'h0);
    ticks(1);
    put(REQ_CLEAR, 16'h0, 1'b0, 7'd0, 7'd0, 32'h0);
    put(REQ_ALL_OFF, 16'h0, 1'b0, 7'd0, 7'd0, 32'h0);
  endtask

  task automatic random_request();
    request_fields_t f;
    req_t            kind;
    int unsigned     pick;
    f.raw = $urandom;
    f.value = 16'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 4))
        0: f.value = 16'h8000;
        1: f.value = 16'h7FFF;
        2: f.value = 16'h8001;
        3: f.value = 16'hFFFF;
        default: f.value = 16'h0000;
      endcase
    end
    f.pad = 1'($urandom_range(0, 1));
    f.hour = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(0, 99));
    f.minute = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(0, 99));
    pick = $urandom_range(0, 99);
    if (pick < 45)      kind = REQ_TICK;
    else if (pick < 55) kind = REQ_RAW;
    else if (pick < 65) kind = REQ_NUMBER;
    else if (pick < 72) kind = REQ_TEMP;
    else if (pick < 80) kind = REQ_TIME;
    else if (pick < 85) kind = REQ_SET_ALL;
    else if (pick < 93) kind = REQ_CLEAR;
    else                kind = REQ_ALL_OFF;
    send_request(kind, f);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cfg_write(32'd0);
    cfg_readback(32'd0);
    directed_requests();
    settle();

    cfg_write(32'd1);
    cfg_readback(32'd1);
    repeat (44) random_request();
    settle();

    cfg_write(32'd0);
    cfg_readback(32'd0);
    repeat (44) random_request();
    settle();

    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("Sent %0d requests of every kind in both polarities, checked %0d results",
             requests_sent, sb.frames_checked);
    $display("Long output hold-off applied: %0d, mismatches: %0d", hold_done, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
